[hw/rtl/lir_pkg.sv]
// lir_pkg: shared constants and types for the linear interpolation resampler
// used by every module under hw/rtl; no dependencies
`default_nettype none

package lir_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int STEP_W          = 19;
	localparam int CFG_INDEX_W     = 1;
	localparam int QUEUE_DEPTH     = 4;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PHASE_STEP     = 1'b0,
		CFG_INTERPOLATE_ON = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic              interpolate_on;
	} cfg_t;

endpackage

`default_nettype wire

[hw/rtl/lir_front.sv]
// lir_front: accepts source frames, keeps the frame pair and the phase,
// and issues one queue entry per output frame; depends on lir_pkg
`default_nettype none

module lir_front import lir_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int EW         = 4 * SAMPLE_BITS + FRAC_BITS + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] in_left,
	input  wire logic [SAMPLE_BITS-1:0] in_right,
	input  wire logic                   in_restart,
	output logic                        push_valid,
	input  wire logic                   push_ready,
	output logic [EW-1:0]               push_data
);

	localparam int PW = FRAC_BITS + 3;
	localparam int CW = (PW > STEP_W) ? PW : STEP_W;
	localparam logic [PW-1:0] UNIT = PW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] STEP_LO = CW'(1) << (FRAC_BITS - 2);
	localparam logic [CW-1:0] STEP_HI = CW'(1) << (FRAC_BITS + 2);

	typedef enum logic {F_IDLE, F_EMIT} fstate_t;

	fstate_t                state_q;
	logic [1:0]             prime_q;
	logic [PW-1:0]          phase_q;
	logic [SAMPLE_BITS-1:0] cur_l_q, cur_r_q, fol_l_q, fol_r_q;

	logic [CW-1:0]          step_ext;
	logic [PW-1:0]          step;
	logic [PW-1:0]          phase_sum;
	logic [PW-1:0]          phase_sub;
	logic [1:0]             level;
	logic [FRAC_BITS-1:0]   frac;
	logic                   last;

	always_comb begin
		step_ext = CW'(cfg.phase_step);
		if (step_ext < STEP_LO) begin
			step_ext = STEP_LO;
		end else if (step_ext > STEP_HI) begin
			step_ext = STEP_HI;
		end
		step      = step_ext[PW-1:0];
		phase_sum = phase_q + step;
		phase_sub = (phase_q >= UNIT) ? phase_q - UNIT : '0;
		level     = in_restart ? 2'd0 : prime_q;
		frac      = cfg.interpolate_on ? phase_q[FRAC_BITS-1:0] : '0;
		last      = (phase_sum >= UNIT);
	end

	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_EMIT);
	assign push_data  = {last, frac, fol_r_q, fol_l_q, cur_r_q, cur_l_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			prime_q <= 2'd0;
			phase_q <= '0;
			cur_l_q <= '0;
			cur_r_q <= '0;
			fol_l_q <= '0;
			fol_r_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						if (level == 2'd0) begin
							cur_l_q <= in_left;
							cur_r_q <= in_right;
							phase_q <= '0;
							prime_q <= 2'd1;
						end else if (level == 2'd1) begin
							fol_l_q <= in_left;
							fol_r_q <= in_right;
							prime_q <= 2'd2;
							if (phase_q < UNIT) begin
								state_q <= F_EMIT;
							end
						end else begin
							cur_l_q <= fol_l_q;
							cur_r_q <= fol_r_q;
							fol_l_q <= in_left;
							fol_r_q <= in_right;
							phase_q <= phase_sub;
							if (phase_sub < UNIT) begin
								state_q <= F_EMIT;
							end
						end
					end
				end
				F_EMIT: begin
					if (push_ready) begin
						phase_q <= phase_sum;
						if (last) begin
							state_q <= F_IDLE;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lir_queue.sv]
// lir_queue: small first-in first-out queue of output frame jobs between
// the front and the back; depends on lir_pkg
`default_nettype none

module lir_queue import lir_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign wr_ready = (count_q != NW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lir_back.sv]
// lir_back: two-stage interpolation pipeline, multiply then floor and add,
// with the output register; depends on lir_pkg
`default_nettype none

module lir_back import lir_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int EW         = 4 * SAMPLE_BITS + FRAC_BITS + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire logic [EW-1:0]          job_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SAMPLE_BITS-1:0]      out_left,
	output logic [SAMPLE_BITS-1:0]      out_right,
	output logic                        out_last
);

	localparam int DW = SAMPLE_BITS + 1;
	localparam int MW = DW + FRAC_BITS + 1;

	logic [SAMPLE_BITS-1:0] cur_l, cur_r, fol_l, fol_r;
	logic [FRAC_BITS-1:0]   frac;
	logic                   last;
	logic signed [DW-1:0]   diff_l, diff_r;
	logic signed [MW-1:0]   prod_l, prod_r;

	logic                   v_s1;
	logic signed [MW-1:0]   prod_l_s1, prod_r_s1;
	logic [SAMPLE_BITS-1:0] cur_l_s1, cur_r_s1;
	logic                   last_s1;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_l_q, out_r_q;
	logic                   out_last_q;

	logic                   out_free, adv_s1;
	logic signed [MW-1:0]   sh_l, sh_r;

	assign {last, frac, fol_r, fol_l, cur_r, cur_l} = job_data;

	always_comb begin
		diff_l = $signed({fol_l[SAMPLE_BITS-1], fol_l}) - $signed({cur_l[SAMPLE_BITS-1], cur_l});
		diff_r = $signed({fol_r[SAMPLE_BITS-1], fol_r}) - $signed({cur_r[SAMPLE_BITS-1], cur_r});
		prod_l = MW'(diff_l) * MW'($signed({1'b0, frac}));
		prod_r = MW'(diff_r) * MW'($signed({1'b0, frac}));
		sh_l   = prod_l_s1 >>> FRAC_BITS;
		sh_r   = prod_r_s1 >>> FRAC_BITS;
	end

	assign out_free  = !out_valid_q || out_ready;
	assign adv_s1    = v_s1 && out_free;
	assign job_ready = !v_s1 || out_free;

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			prod_l_s1 <= prod_l;
			prod_r_s1 <= prod_r;
			cur_l_s1  <= cur_l;
			cur_r_s1  <= cur_r;
			last_s1   <= last;
		end
		if (adv_s1) begin
			out_l_q    <= cur_l_s1 + sh_l[SAMPLE_BITS-1:0];
			out_r_q    <= cur_r_s1 + sh_r[SAMPLE_BITS-1:0];
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_ready) begin
				v_s1 <= job_valid;
			end
			if (out_free) begin
				out_valid_q <= v_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/linear_interp_resampler.sv]
// linear_interp_resampler: top level, configuration registers and the
// front, queue and back; depends on lir_pkg, lir_front, lir_queue, lir_back
//
// Stereo linear interpolation resampler. Each source beat is taken by the
// front, which then issues one output frame job per cycle while the queue
// has room; a beat holds the input until its n jobs are issued, n (0 to 4)
// being the number of output frames it causes, set by phase_step. The back
// multiplies and adds in a two-stage pipeline and delivers one frame per
// cycle through an output register while m_tready allows; a four-entry
// queue lets the input run ahead of a stalled output. The first two beats
// after reset or restart fill the frame pair; output begins at the second.
`default_nettype none

module linear_interp_resampler import lir_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int DATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [DATA_W-1:0]      s_tdata,  // src_left, src_right
	input  wire logic                   s_tuser,  // restart
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [DATA_W-1:0]           m_tdata,  // out_left, out_right
	output logic                        m_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [STEP_W-1:0]      cfg_data
);

	localparam int EW = 4 * SAMPLE_BITS + FRAC_BITS + 1;

	cfg_t                   cfg_q;
	logic                   push_valid, push_ready, job_valid, job_ready;
	logic [EW-1:0]          push_data, job_data;
	logic [SAMPLE_BITS-1:0] out_left, out_right;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step     <= STEP_RESET;
			cfg_q.interpolate_on <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PHASE_STEP:     cfg_q.phase_step     <= cfg_data;
				CFG_INTERPOLATE_ON: cfg_q.interpolate_on <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lir_front #(
		.FRAC_BITS   (FRAC_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_left    (s_tdata[SAMPLE_BITS-1:0]),
		.in_right   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.in_restart (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lir_queue #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (job_valid),
		.rd_ready (job_ready),
		.rd_data  (job_data)
	);

	lir_back #(
		.FRAC_BITS   (FRAC_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_data  (job_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_left  (out_left),
		.out_right (out_right),
		.out_last  (m_tlast)
	);

	assign m_tdata = DATA_W'({out_right, out_left});

endmodule

`default_nettype wire

[hw/rtl/lir_checker.sv]
// lir_checker: port-level assertions for the resampler top level, with the
// bind that attaches them; depends on lir_pkg and linear_interp_resampler
`default_nettype none

module lir_checker import lir_pkg::*; #(
	parameter int DATA_W = 32
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [DATA_W-1:0] m_tdata,
	input wire logic              m_tlast
);

	// output beats since the last tlast
	logic [2:0] run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (m_tvalid && m_tready) begin
			run_q <= m_tlast ? 3'd0 : run_q + 3'd1;
		end
	end

	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output beat offered during reset");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output beat changed");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> run_q < 3'd3)
		else $error("more than four output beats for one source beat");

endmodule

bind linear_interp_resampler lir_checker #(
	.DATA_W (DATA_W)
) u_lir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
